// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ACA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define ACA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aca_pkg.sv =====
// ---------------------------------------------------------------------------
// aca_pkg
// Types and fixed constants of the multi-pattern occurrence graph unit.
// ---------------------------------------------------------------------------
package aca_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned SymW  = 5;
  localparam int unsigned StrW  = 5;

  // cap on results per scanned letter
  localparam int unsigned MaxResults = 32;
  localparam int unsigned CntW       = 6;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_SCAN   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [StrW-1:0] container_string;
    logic [StrW-1:0] contained_string;
    logic            overflow;
    logic            last_result;
  } res_t;

endpackage

// ===== rtl/aca_if.sv =====
// ---------------------------------------------------------------------------
// aca_in_if / aca_out_if
// Valid/ready channels for input letters and result transactions.
// ---------------------------------------------------------------------------
interface aca_in_if;
  logic                      valid;
  logic                      ready;
  logic [aca_pkg::ModeW-1:0] mode;
  logic [aca_pkg::SymW-1:0]  symbol;
  logic [aca_pkg::StrW-1:0]  string_index;
  logic                      last_symbol;

  modport source (output valid, mode, symbol, string_index, last_symbol, input ready);
  modport sink   (input valid, mode, symbol, string_index, last_symbol, output ready);
endinterface

interface aca_out_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [aca_pkg::StrW-1:0] container_string;
  logic [aca_pkg::StrW-1:0] contained_string;
  logic                     overflow;
  logic                     last_result;

  modport source (output valid, kind, container_string, contained_string, overflow,
                  last_result, input ready);
  modport sink   (input valid, kind, container_string, contained_string, overflow,
                  last_result, output ready);
endinterface

// ===== rtl/aca_ram.sv =====
// ---------------------------------------------------------------------------
// aca_ram
// Single write port, single read port memory with registered read data.
// ---------------------------------------------------------------------------
module aca_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/aca_obuf.sv =====
// ---------------------------------------------------------------------------
// aca_obuf
// Output register: hold one result transaction until the sink takes it.
// ---------------------------------------------------------------------------
module aca_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  aca_pkg::res_t     push_data_i,
  output logic              push_ready_o,
  aca_out_if.source         out_o
);

  logic          valid_q;
  aca_pkg::res_t data_q;

  assign push_ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else if (push_valid_i && push_ready_o) begin
      valid_q <= 1'b1;
      data_q  <= push_data_i;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.kind             = data_q.kind;
  assign out_o.container_string = data_q.container_string;
  assign out_o.contained_string = data_q.contained_string;
  assign out_o.overflow         = data_q.overflow;
  assign out_o.last_result      = data_q.last_result;

endmodule

// ===== rtl/multi_pattern_occurrence_graph_unit.sv =====
// ---------------------------------------------------------------------------
// multi_pattern_occurrence_graph_unit
// Aho-Corasick trie, link build and occurrence scan over memory-held state.
// ---------------------------------------------------------------------------
// Insert letter: a transition read, then a write. Scan letter: a transition read,
// then one step per terminal-chain node visited, held while the sink stalls a result.
// Link build: a breadth-first walk over the nodes, their edge slots and suffix hops.
// Reset and the clear-all mode run a clearing pass over the transition, terminal-link,
// string-end and occurrence memories, during which no letter is taken.
// One transaction at a time; the sequencer and one memory read per cycle set the rate.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_pattern_occurrence_graph_unit #(
  parameter int unsigned MAX_NODES   = 1024,
  parameter int unsigned ALPHABET    = 26,
  parameter int unsigned NUM_STRINGS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aca_in_if.sink     in_i,
  aca_out_if.source  out_o
);

  localparam int unsigned NW   = $clog2(MAX_NODES);
  localparam int unsigned GD   = MAX_NODES * ALPHABET;
  localparam int unsigned GA   = $clog2(GD);
  localparam int unsigned IW   = $clog2(ALPHABET);
  localparam int unsigned OA   = $clog2(NUM_STRINGS);
  localparam int unsigned SW   = aca_pkg::StrW;
  localparam int unsigned CW   = aca_pkg::CntW;
  localparam logic [NW:0] MaxS = (NW+1)'(MAX_NODES);

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    INS_RD, INS_WR,
    SC_RD, SC_CUR, SC_HEAD, SC_STEP, SC_FIN,
    BL_INIT, BL_POP, BL_U, BL_SU, BL_CH, BL_CHD, BL_WALK, BL_WSUF, BL_TERM, BL_DONE
  } state_e;

  // flat transition address of (node, letter)
  function automatic logic [GA-1:0] gaddr(input logic [31:0] n, input logic [31:0] s);
    return GA'(n * ALPHABET + s);
  endfunction

  state_e state_q, state_d;

  logic [SW-1:0]          sym_q, sym_d;
  logic [SW-1:0]          sidx_q, sidx_d;
  logic                   last_q, last_d;
  logic [NW-1:0]          ic_q, ic_d, sc_q, sc_d, nc_q, nc_d;
  logic                   ovf_q, ovf_d;
  logic [GA-1:0]          clr_q, clr_d;
  logic [NW-1:0]          k_q, k_d;
  logic [NW:0]            steps_q, steps_d;
  logic [CW-1:0]          n_q, n_d;
  logic [NUM_STRINGS-1:0] row_q, row_d;
  logic                   pend_v_q, pend_v_d;
  logic [SW-1:0]          pend_q, pend_d;
  logic [NW:0]            head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]          u_q, u_d, su_q, su_d, v_q, v_d, j_q, j_d, lv_q, lv_d;
  logic [IW-1:0]          i_q, i_d;

  // memory ports
  logic                   g_we;
  logic [GA-1:0]          g_wa, g_ra;
  logic [NW-1:0]          g_wd, g_rdata;
  logic                   suf_we;
  logic [NW-1:0]          suf_wa, suf_wd, suf_ra, suf_rdata;
  logic                   tl_we;
  logic [NW-1:0]          tl_wa, tl_ra;
  logic [NW:0]            tl_wd, tl_rdata;
  logic                   ts_we;
  logic [NW-1:0]          ts_wa, ts_ra;
  logic [SW:0]            ts_wd, ts_rdata;
  logic                   occ_we;
  logic [OA-1:0]          occ_wa, occ_ra;
  logic [NUM_STRINGS-1:0] occ_wd, occ_rdata;
  logic                   q_we;
  logic [NW-1:0]          q_wa, q_wd, q_ra, q_rdata;

  logic                   in_ready;
  logic                   res_valid, res_ready;
  aca_pkg::res_t          res_data;

  logic [SW-1:0]          t_str;
  logic [NW-1:0]          t_next;
  logic                   t_next_v;

  assign t_str    = ts_rdata[SW-1:0];
  assign t_next   = tl_rdata[NW-1:0];
  assign t_next_v = tl_rdata[NW];

  assign in_i.ready = in_ready;

  // transition table: child per (node, letter), zero means none
  aca_ram #(.Width(NW), .Depth(GD)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_wa), .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rdata)
  );
  // suffix links, written by the link build only
  aca_ram #(.Width(NW), .Depth(MAX_NODES)) u_suf (
    .clk_i, .we_i(suf_we), .waddr_i(suf_wa), .wdata_i(suf_wd), .raddr_i(suf_ra),
    .rdata_o(suf_rdata)
  );
  // nearest terminal link {valid, node}
  aca_ram #(.Width(NW+1), .Depth(MAX_NODES)) u_tl (
    .clk_i, .we_i(tl_we), .waddr_i(tl_wa), .wdata_i(tl_wd), .raddr_i(tl_ra),
    .rdata_o(tl_rdata)
  );
  // string ending at a node {valid, string}
  aca_ram #(.Width(SW+1), .Depth(MAX_NODES)) u_ts (
    .clk_i, .we_i(ts_we), .waddr_i(ts_wa), .wdata_i(ts_wd), .raddr_i(ts_ra),
    .rdata_o(ts_rdata)
  );
  // occurrence bit matrix, one row per container string
  aca_ram #(.Width(NUM_STRINGS), .Depth(NUM_STRINGS)) u_occ (
    .clk_i, .we_i(occ_we), .waddr_i(occ_wa), .wdata_i(occ_wd), .raddr_i(occ_ra),
    .rdata_o(occ_rdata)
  );
  // breadth-first node queue of the link build
  aca_ram #(.Width(NW), .Depth(MAX_NODES)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rdata)
  );

  aca_obuf u_obuf (
    .clk_i, .rst_ni,
    .push_valid_i(res_valid), .push_data_i(res_data), .push_ready_o(res_ready),
    .out_o
  );

  always_comb begin
    state_d  = state_q;
    sym_d    = sym_q;
    sidx_d   = sidx_q;
    last_d   = last_q;
    ic_d     = ic_q;
    sc_d     = sc_q;
    nc_d     = nc_q;
    ovf_d    = ovf_q;
    clr_d    = clr_q;
    k_d      = k_q;
    steps_d  = steps_q;
    n_d      = n_q;
    row_d    = row_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    head_d   = head_q;
    tail_d   = tail_q;
    u_d      = u_q;
    su_d     = su_q;
    v_d      = v_q;
    j_d      = j_q;
    lv_d     = lv_q;
    i_d      = i_q;

    g_we   = 1'b0; g_wa   = '0; g_wd   = '0; g_ra   = '0;
    suf_we = 1'b0; suf_wa = '0; suf_wd = '0; suf_ra = '0;
    tl_we  = 1'b0; tl_wa  = '0; tl_wd  = '0; tl_ra  = k_q;
    ts_we  = 1'b0; ts_wa  = '0; ts_wd  = '0; ts_ra  = k_q;
    occ_we = 1'b0; occ_wa = '0; occ_wd = '0; occ_ra = OA'(sidx_q);
    q_we   = 1'b0; q_wa   = '0; q_wd   = '0; q_ra   = '0;

    in_ready  = 1'b0;
    res_valid = 1'b0;
    res_data  = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep the transition, terminal-link, string-end and occurrence memories to zero
        g_we = 1'b1;
        g_wa = clr_q;
        if (32'(clr_q) < MAX_NODES) begin
          tl_we = 1'b1;
          tl_wa = NW'(clr_q);
          ts_we = 1'b1;
          ts_wa = NW'(clr_q);
        end
        if (32'(clr_q) < NUM_STRINGS) begin
          occ_we = 1'b1;
          occ_wa = OA'(clr_q);
        end
        if (clr_q == GA'(GD - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          sym_d  = in_i.symbol;
          sidx_d = in_i.string_index;
          last_d = in_i.last_symbol;
          unique case (aca_pkg::mode_e'(in_i.mode))
            aca_pkg::MODE_INSERT: begin
              if (32'(in_i.symbol) < ALPHABET && 32'(in_i.string_index) < NUM_STRINGS) begin
                state_d = INS_RD;
              end
            end
            aca_pkg::MODE_SCAN: begin
              if (32'(in_i.symbol) < ALPHABET && 32'(in_i.string_index) < NUM_STRINGS) begin
                state_d = SC_RD;
              end
            end
            aca_pkg::MODE_BUILD: begin
              state_d = BL_INIT;
            end
            aca_pkg::MODE_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
              nc_d    = '0;
              ic_d    = '0;
              sc_d    = '0;
              ovf_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end

      INS_RD: begin
        g_ra    = gaddr(32'(ic_q), 32'(sym_q));
        state_d = INS_WR;
      end

      INS_WR: begin
        // allocate a child when missing, drop the letter when the trie is full
        if (g_rdata == '0) begin
          if (nc_q < NW'(MAX_NODES - 1)) begin
            nc_d = nc_q + 1'b1;
            g_we = 1'b1;
            g_wa = gaddr(32'(ic_q), 32'(sym_q));
            g_wd = nc_q + 1'b1;
            ic_d = nc_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          ic_d = g_rdata;
        end
        if (last_q) begin
          if (ic_d != '0) begin
            ts_we = 1'b1;
            ts_wa = ic_d;
            ts_wd = {1'b1, sidx_q};
          end
          ic_d = '0;
        end
        state_d = ST_IDLE;
      end

      SC_RD: begin
        g_ra    = gaddr(32'(sc_q), 32'(sym_q));
        state_d = SC_CUR;
      end

      SC_CUR: begin
        sc_d    = last_q ? '0 : g_rdata;
        ts_ra   = g_rdata;
        tl_ra   = g_rdata;
        k_d     = g_rdata;
        steps_d = '0;
        n_d     = '0;
        state_d = SC_HEAD;
      end

      SC_HEAD: begin
        row_d = occ_rdata;
        if (ts_rdata[SW]) begin
          state_d = SC_STEP;
        end else if (t_next_v) begin
          k_d     = t_next;
          ts_ra   = t_next;
          tl_ra   = t_next;
          state_d = SC_STEP;
        end else begin
          state_d = SC_FIN;
        end
      end

      SC_STEP: begin
        if (steps_q >= MaxS) begin
          state_d = SC_FIN;
        end else if (t_str != sidx_q && row_q[OA'(t_str)]) begin
          // edge already recorded: stop the walk
          state_d = SC_FIN;
        end else if (t_str != sidx_q && n_q < CW'(aca_pkg::MaxResults) && pend_v_q &&
                     !res_ready) begin
          // hold until the output register frees up
          state_d = SC_STEP;
        end else begin
          steps_d = steps_q + 1'b1;
          if (t_str != sidx_q) begin
            row_d[OA'(t_str)] = 1'b1;
            occ_we = 1'b1;
            occ_wa = OA'(sidx_q);
            occ_wd = row_d;
            if (n_q < CW'(aca_pkg::MaxResults)) begin
              if (pend_v_q) begin
                res_valid = 1'b1;
                res_data  = '{kind: aca_pkg::KIND_EDGE, container_string: sidx_q,
                              contained_string: pend_q, overflow: ovf_q, last_result: 1'b0};
              end
              pend_d   = t_str;
              pend_v_d = 1'b1;
              n_d      = n_q + 1'b1;
            end
          end
          if (t_next_v) begin
            k_d   = t_next;
            ts_ra = t_next;
            tl_ra = t_next;
          end else begin
            state_d = SC_FIN;
          end
        end
      end

      SC_FIN: begin
        // the held edge is the final result of this letter
        if (pend_v_q) begin
          res_valid = 1'b1;
          res_data  = '{kind: aca_pkg::KIND_EDGE, container_string: sidx_q,
                        contained_string: pend_q, overflow: ovf_q, last_result: 1'b1};
          if (res_ready) begin
            pend_v_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      BL_INIT: begin
        q_we    = 1'b1;
        head_d  = '0;
        tail_d  = (NW+1)'(1);
        state_d = BL_POP;
      end

      BL_POP: begin
        if (head_q < tail_q) begin
          q_ra    = NW'(head_q);
          head_d  = head_q + 1'b1;
          state_d = BL_U;
        end else begin
          state_d = BL_DONE;
        end
      end

      BL_U: begin
        u_d     = q_rdata;
        suf_ra  = q_rdata;
        i_d     = '0;
        state_d = BL_SU;
      end

      BL_SU: begin
        su_d    = suf_rdata;
        state_d = BL_CH;
      end

      BL_CH: begin
        g_ra    = gaddr(32'(u_q), 32'(i_q));
        state_d = BL_CHD;
      end

      BL_CHD: begin
        if (g_rdata == '0) begin
          if (i_q == IW'(ALPHABET - 1)) begin
            state_d = BL_POP;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = BL_CH;
          end
        end else begin
          v_d = g_rdata;
          if (u_q == '0) begin
            lv_d    = '0;
            ts_ra   = '0;
            tl_ra   = '0;
            state_d = BL_TERM;
          end else begin
            j_d     = su_q;
            steps_d = '0;
            g_ra    = gaddr(32'(su_q), 32'(i_q));
            state_d = BL_WALK;
          end
        end
      end

      BL_WALK: begin
        // follow suffix links until a node has this letter or the root is hit
        if (j_q != '0 && g_rdata == '0 && steps_q < MaxS) begin
          suf_ra  = j_q;
          steps_d = steps_q + 1'b1;
          state_d = BL_WSUF;
        end else begin
          lv_d    = g_rdata;
          ts_ra   = g_rdata;
          tl_ra   = g_rdata;
          state_d = BL_TERM;
        end
      end

      BL_WSUF: begin
        j_d     = suf_rdata;
        g_ra    = gaddr(32'(suf_rdata), 32'(i_q));
        state_d = BL_WALK;
      end

      BL_TERM: begin
        suf_we = 1'b1;
        suf_wa = v_q;
        suf_wd = lv_q;
        tl_we  = 1'b1;
        tl_wa  = v_q;
        tl_wd  = ts_rdata[SW] ? {1'b1, lv_q} : tl_rdata;
        if (tail_q < MaxS) begin
          q_we   = 1'b1;
          q_wa   = NW'(tail_q);
          q_wd   = v_q;
          tail_d = tail_q + 1'b1;
        end
        if (i_q == IW'(ALPHABET - 1)) begin
          state_d = BL_POP;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = BL_CH;
        end
      end

      BL_DONE: begin
        res_valid = 1'b1;
        res_data  = '{kind: aca_pkg::KIND_DONE, container_string: '0, contained_string: '0,
                      overflow: ovf_q, last_result: 1'b1};
        if (res_ready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      sym_q    <= '0;
      sidx_q   <= '0;
      last_q   <= 1'b0;
      ic_q     <= '0;
      sc_q     <= '0;
      nc_q     <= '0;
      ovf_q    <= 1'b0;
      clr_q    <= '0;
      k_q      <= '0;
      steps_q  <= '0;
      n_q      <= '0;
      row_q    <= '0;
      pend_v_q <= 1'b0;
      pend_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      u_q      <= '0;
      su_q     <= '0;
      v_q      <= '0;
      j_q      <= '0;
      lv_q     <= '0;
      i_q      <= '0;
    end else begin
      state_q  <= state_d;
      sym_q    <= sym_d;
      sidx_q   <= sidx_d;
      last_q   <= last_d;
      ic_q     <= ic_d;
      sc_q     <= sc_d;
      nc_q     <= nc_d;
      ovf_q    <= ovf_d;
      clr_q    <= clr_d;
      k_q      <= k_d;
      steps_q  <= steps_d;
      n_q      <= n_d;
      row_q    <= row_d;
      pend_v_q <= pend_v_d;
      pend_q   <= pend_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      u_q      <= u_d;
      su_q     <= su_d;
      v_q      <= v_d;
      j_q      <= j_d;
      lv_q     <= lv_d;
      i_q      <= i_d;
    end
  end

  `ACA_ASSERT(a_clear_blocks_input, (state_q == ST_CLEAR) |-> !in_ready, "input in clear")
  `ACA_ASSERT(a_pend_in_scan, pend_v_q |-> (state_q == SC_STEP || state_q == SC_FIN), "stray edge")
  `ACA_ASSERT(a_new_node_nonzero, (g_we && state_q == INS_WR) |-> (g_wd != '0), "root as child")
  `ACA_ASSERT_NEXT(a_done_idle, state_q == BL_DONE && res_ready, state_q == ST_IDLE, "stuck")

endmodule

// ===== tb/occurrence_checker.sv =====
// ---------------------------------------------------------------------------
// occurrence_checker
// Watches both channels of the occurrence graph unit, keeps its own trie,
// links and occurrence matrix, and compares every result with the prediction.
// ---------------------------------------------------------------------------
module occurrence_checker (
  input  logic clk_i,
  input  logic rst_ni,
  aca_in_if    in_mon,
  aca_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   edges_seen_o,
  output int   builds_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Nodes   = 1024;
  localparam int Letters = 26;
  localparam int Strings = 32;

  logic [9:0]               child_mem [Nodes][Letters];
  logic [9:0]               fail_node [Nodes];
  logic [9:0]               term_next [Nodes];
  logic                     term_next_ok [Nodes];
  logic [aca_pkg::StrW-1:0] term_owner [Nodes];
  logic                     term_owner_ok [Nodes];
  logic [31:0]              occ_rows [Strings];
  int                       node_total;
  int                       insert_at;
  int                       scan_at;
  logic                     trie_full;

  int fails   = 0;
  int pending = 0;
  int edges   = 0;
  int builds  = 0;

  aca_pkg::res_t expected_results[$];

  assign fail_count_o  = fails;
  assign pending_o     = pending;
  assign edges_seen_o  = edges;
  assign builds_seen_o = builds;

  function automatic void wipe_state();
    for (int n = 0; n < Nodes; n++) begin
      for (int l = 0; l < Letters; l++) child_mem[n][l] = '0;
      fail_node[n]     = '0;
      term_next[n]     = '0;
      term_next_ok[n]  = 1'b0;
      term_owner[n]    = '0;
      term_owner_ok[n] = 1'b0;
    end
    foreach (occ_rows[s]) occ_rows[s] = '0;
    node_total = 0;
    insert_at  = 0;
    scan_at    = 0;
    trie_full  = 1'b0;
  endfunction

  function automatic aca_pkg::res_t make_res(logic kind, int outer, int inner, logic last);
    aca_pkg::res_t r;
    r.kind             = kind;
    r.container_string = outer[aca_pkg::StrW-1:0];
    r.contained_string = inner[aca_pkg::StrW-1:0];
    r.overflow         = trie_full;
    r.last_result      = last;
    return r;
  endfunction

  // Breadth-first pass: suffix links, then nearest terminal suffix.
  function automatic void link_trie();
    int order [Nodes];
    int head, tail, u, v, j, hops, lv;
    head = 0;
    tail = 0;
    order[tail++] = 0;
    while (head < tail) begin
      u = order[head++];
      for (int l = 0; l < Letters; l++) begin
        v = child_mem[u][l];
        if (v == 0) continue;
        if (u == 0) lv = 0;
        else begin
          j = fail_node[u];
          hops = 0;
          while (j != 0 && child_mem[j][l] == 0 && hops < Nodes) begin
            j = fail_node[j];
            hops++;
          end
          lv = child_mem[j][l];
        end
        fail_node[v] = lv[9:0];
        if (term_owner_ok[lv]) begin
          term_next[v]    = lv[9:0];
          term_next_ok[v] = 1'b1;
        end else begin
          term_next[v]    = term_next[lv];
          term_next_ok[v] = term_next_ok[lv];
        end
        if (tail < Nodes) order[tail++] = v;
      end
    end
    expected_results.push_back(make_res(aca_pkg::KIND_DONE, 0, 0, 1'b1));
  endfunction

  function automatic void add_letter(int sym, int sidx, logic last);
    int here, kid;
    here = insert_at;
    kid  = child_mem[here][sym];
    if (kid == 0) begin
      if (node_total < Nodes - 1) begin
        node_total++;
        kid = node_total;
        child_mem[here][sym] = kid[9:0];
      end else trie_full = 1'b1;
    end
    if (kid != 0) here = kid;
    insert_at = here;
    if (last) begin
      if (here != 0) begin
        term_owner[here]    = sidx[aca_pkg::StrW-1:0];
        term_owner_ok[here] = 1'b1;
      end
      insert_at = 0;
    end
  endfunction

  // Walk the terminal chain; stop at the first edge already known.
  function automatic void scan_letter(int sym, int sidx, logic last);
    int            cur, k, hops, found;
    logic          live;
    aca_pkg::res_t batch[$];
    cur  = child_mem[scan_at][sym];
    k    = cur;
    live = 1'b1;
    hops = 0;
    scan_at = last ? 0 : cur;
    if (!term_owner_ok[k]) begin
      live = term_next_ok[k];
      k    = term_next[k];
    end
    while (live && hops < Nodes) begin
      found = term_owner[k];
      hops++;
      if (found != sidx) begin
        if (occ_rows[sidx][found]) break;
        occ_rows[sidx][found] = 1'b1;
        if (batch.size() < aca_pkg::MaxResults)
          batch.push_back(make_res(aca_pkg::KIND_EDGE, sidx, found, 1'b0));
      end
      live = term_next_ok[k];
      k    = term_next[k];
    end
    if (batch.size() > 0) batch[batch.size()-1].last_result = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endfunction

  function automatic void predict(aca_pkg::mode_e m, int sym, int sidx, logic last);
    case (m)
      aca_pkg::MODE_CLEAR: wipe_state();
      aca_pkg::MODE_BUILD: link_trie();
      default: begin
        if (sym < Letters && sidx < Strings) begin
          if (m == aca_pkg::MODE_INSERT) add_letter(sym, sidx, last);
          else scan_letter(sym, sidx, last);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    aca_pkg::res_t got, want;
    if (!rst_ni) begin
      wipe_state();
      expected_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict(aca_pkg::mode_e'(in_mon.mode), in_mon.symbol, in_mon.string_index,
                in_mon.last_symbol);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kind             = out_mon.kind;
        got.container_string = out_mon.container_string;
        got.contained_string = out_mon.contained_string;
        got.overflow         = out_mon.overflow;
        got.last_result      = out_mon.last_result;
        if (got.kind == aca_pkg::KIND_DONE) builds++;
        else edges++;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives letters into the occurrence graph unit: a directed opening, then
// random build-and-scan rounds with random idling on both channels. The
// checker beside the block judges every result.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // generous cap: a clearing pass per round, link builds, slow handshakes
  localparam int CycleLimit = 3000000;

  logic clk_i;
  logic rst_ni;

  aca_in_if  in_ch ();
  aca_out_if out_ch ();

  int fail_count, pending, edges_seen, builds_seen;
  int cycle_count = 0;
  int gap_max;     // sender idling ceiling, 0 gives back-to-back stretches
  int stall_max;   // receiver idling ceiling
  int stall_left = 0;
  logic out_fire = 1'b0;
  int random_items;

  // stored words of the current round, for rescanning
  int word_sym [8][8];
  int word_len [8];
  int word_idx [8];
  int word_total;

  multi_pattern_occurrence_graph_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  occurrence_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .edges_seen_o (edges_seen),
    .builds_seen_o(builds_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Timeout watchdog on a plain cycle count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: hold ready low for a drawn number of cycles after each
  // transaction, then raise it again.
  always @(posedge clk_i) begin
    out_fire <= out_ch.valid && out_ch.ready;
  end

  always @(negedge clk_i) begin
    if (out_fire) stall_left = $urandom_range(0, stall_max);
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Present one letter transaction and hold it until the block takes it.
  task automatic send(aca_pkg::mode_e m, int sym, int sidx, bit last);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.mode         = m;
    in_ch.symbol       = sym[aca_pkg::SymW-1:0];
    in_ch.string_index = sidx[aca_pkg::StrW-1:0];
    in_ch.last_symbol  = last;
    in_ch.valid        = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic insert_word(int w);
    for (int i = 0; i < word_len[w]; i++)
      send(aca_pkg::MODE_INSERT, word_sym[w][i], word_idx[w], i == word_len[w] - 1);
  endtask

  task automatic scan_word(int w, int sidx);
    for (int i = 0; i < word_len[w]; i++)
      send(aca_pkg::MODE_SCAN, word_sym[w][i], sidx, i == word_len[w] - 1);
  endtask

  // Drain outstanding results before the next stimulus phase.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int letters, sidx, w, noise;
    gap_max            = 5;
    stall_max          = 5;
    random_items       = 0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = aca_pkg::MODE_INSERT;
    in_ch.symbol       = '0;
    in_ch.string_index = '0;
    in_ch.last_symbol  = 1'b0;
    rst_ni             = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening: "ab" as 0, "b" as 31, "z" as 5, ignored letters.
    send(aca_pkg::MODE_INSERT, 0, 0, 0);
    send(aca_pkg::MODE_INSERT, 1, 0, 1);
    send(aca_pkg::MODE_INSERT, 1, 31, 1);
    send(aca_pkg::MODE_INSERT, 31, 3, 1);   // letter out of range
    send(aca_pkg::MODE_INSERT, 26, 3, 0);   // letter out of range
    send(aca_pkg::MODE_INSERT, 25, 5, 1);
    // scan ahead of any link build: chains end at once
    send(aca_pkg::MODE_SCAN, 0, 0, 0);
    send(aca_pkg::MODE_SCAN, 1, 0, 1);
    send(aca_pkg::MODE_BUILD, 0, 0, 0);
    send(aca_pkg::MODE_SCAN, 0, 2, 0);
    send(aca_pkg::MODE_SCAN, 1, 2, 1);      // finds 0 and 31
    send(aca_pkg::MODE_SCAN, 0, 2, 0);
    send(aca_pkg::MODE_SCAN, 1, 2, 1);      // already recorded, stops at once
    send(aca_pkg::MODE_SCAN, 7, 2, 1);      // missing child, back to root
    send(aca_pkg::MODE_SCAN, 25, 5, 1);     // only itself, skipped
    send(aca_pkg::MODE_SCAN, 31, 30, 1);    // ignored letter in scan
    send(aca_pkg::MODE_SCAN, 25, 31, 1);
    settle();
    send(aca_pkg::MODE_CLEAR, 0, 0, 0);

    // Random rounds: insert a few words, build in most rounds, scan words and noise.
    while (random_items < 360) begin
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      letters   = $urandom_range(2, 26);
      word_total = $urandom_range(2, 8);
      for (int k = 0; k < word_total; k++) begin
        word_len[k] = $urandom_range(1, 6);
        word_idx[k] = $urandom_range(0, 31);
        for (int i = 0; i < word_len[k]; i++)
          word_sym[k][i] = $urandom_range(0, letters - 1);
        insert_word(k);
        random_items += word_len[k];
      end
      if ($urandom_range(0, 4) == 0)
        send(aca_pkg::MODE_INSERT, $urandom_range(0, 31), $urandom_range(0, 31),
             1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) != 0) begin
        send(aca_pkg::MODE_BUILD, $urandom_range(0, 31), $urandom_range(0, 31),
             1'($urandom_range(0, 1)));
        random_items++;
      end
      for (int k = 0; k < 2 * word_total; k++) begin
        w    = $urandom_range(0, word_total - 1);
        sidx = ($urandom_range(0, 1) == 0) ? word_idx[w] : $urandom_range(0, 31);
        scan_word(w, sidx);
        random_items += word_len[w];
      end
      noise = $urandom_range(0, 6);
      for (int k = 0; k < noise; k++) begin
        send(aca_pkg::MODE_SCAN, $urandom_range(0, 31), $urandom_range(0, 31),
             1'($urandom_range(0, 1)));
        random_items++;
      end
      settle();
      send(aca_pkg::MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
           1'($urandom_range(0, 1)));
    end

    settle();
    repeat (200) @(negedge clk_i);
    $display("covered %0d random letters after the directed opening", random_items);
    $display("results checked: %0d occurrence edges, %0d link builds",
             edges_seen, builds_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
